// ===== hdl/srrb_pkg.sv =====
// shared types and constants for the selective repeat reorder buffer
package srrb_pkg;

    localparam int SEQ_W      = 32;
    localparam int PORT_W     = 16;
    localparam int HANDLE_W   = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 120;

    localparam logic ALU_SUB = 1'b0;
    localparam logic ALU_INC = 1'b1;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_slot_ctl;

endpackage

// ===== hdl/srrb_alu.sv =====
// shared 32 bit adder used for window distance, ack number and sequence advance
module srrb_alu (
    input  logic                      i_op,
    input  logic [srrb_pkg::SEQ_W-1:0] i_a,
    input  logic [srrb_pkg::SEQ_W-1:0] i_b,
    output logic [srrb_pkg::SEQ_W-1:0] o_y,
    output logic                      o_carry
);

    logic [srrb_pkg::SEQ_W-1:0] w_b;
    logic                       w_cin;

    always_comb begin
        case (i_op)
            srrb_pkg::ALU_SUB: begin
                w_b   = ~i_b;
                w_cin = 1'b1;
            end
            srrb_pkg::ALU_INC: begin
                w_b   = '0;
                w_cin = 1'b1;
            end
            default: begin
                w_b   = '0;
                w_cin = 1'b0;
            end
        endcase
    end

    assign {o_carry, o_y} = {1'b0, i_a} + {1'b0, w_b} + {{srrb_pkg::SEQ_W{1'b0}}, w_cin};

endmodule

// ===== hdl/srrb_slot_store.sv =====
// slot storage: valid bits and payload handles of the receive window
module srrb_slot_store #(
    parameter int WINDOW_SLOTS = 8,
    parameter int SLOT_W       = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srrb_pkg::t_slot_ctl           i_ctl,
    input  logic [SLOT_W-1:0]             i_wr_idx,
    input  logic [srrb_pkg::HANDLE_W-1:0] i_wr_handle,
    input  logic [SLOT_W-1:0]             i_rd_idx,
    input  logic [SLOT_W-1:0]             i_nx_idx,
    output logic [srrb_pkg::HANDLE_W-1:0] o_rd_handle,
    output logic                          o_rd_valid,
    output logic                          o_nx_valid
);

    logic [WINDOW_SLOTS-1:0]         r_valid;
    logic [srrb_pkg::HANDLE_W-1:0]   r_handle [WINDOW_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.wr) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_ctl.clr) begin
                r_valid[i_rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_handle[i_wr_idx] <= i_wr_handle;
        end
    end

    assign o_rd_handle = r_handle[i_rd_idx];
    assign o_rd_valid  = r_valid[i_rd_idx];
    assign o_nx_valid  = r_valid[i_nx_idx];

endmodule

// ===== hdl/selective_repeat_reorder_buffer_unit.sv =====
// receive window top level: sequencer, window state and result register
// the ack item is built in the S_ACK state from the registered input item and loaded into the result register
// each in-order delivery then follows from the S_DLV state, up to WINDOW_SLOTS of them
// the shared adder sequencer takes a new input item only in S_IDLE, after the ack and all deliveries of the last one
// a full result register stalls the sequencer until the item is taken
// synchronous active-low reset clears expected sequence, slot valid bits and output valid
module selective_repeat_reorder_buffer_unit #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // seq_num, src_port, dst_port, payload_handle
    input  logic [srrb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // ack_num, reply_src_port, reply_dst_port, beyond_window, out_handle, out_seq, zero pad
    output logic [srrb_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // kind
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int SEQ_W  = srrb_pkg::SEQ_W;
    localparam int PORT_W = srrb_pkg::PORT_W;
    localparam int HND_W  = srrb_pkg::HANDLE_W;
    localparam int PAD_W  = srrb_pkg::OUT_DATA_W - (2 * SEQ_W + 2 * PORT_W + 1 + HND_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACK  = 2'd1;
    localparam logic [1:0] S_DLV  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SEQ_W-1:0]  r_seq;
    logic [PORT_W-1:0] r_sport, r_dport;
    logic [HND_W-1:0]  r_handle;
    logic [SEQ_W-1:0]  r_dist;
    logic              r_nowrap;
    logic [SEQ_W-1:0]  r_exp;
    logic [SLOT_W-1:0] r_exp_slot;

    logic              r_ovalid;
    logic              r_kind, r_beyond, r_last;
    logic [SEQ_W-1:0]  r_ack, r_oseq;
    logic [PORT_W-1:0] r_rsrc, r_rdst;
    logic [HND_W-1:0]  r_ohandle;

    logic              w_op;
    logic [SEQ_W-1:0]  w_a, w_y;
    logic              w_carry;
    logic              w_accept, w_load;
    logic              w_inside, w_beyond;
    logic [SLOT_W:0]   w_sum;
    logic [SLOT_W-1:0] w_wr_idx, w_nx_slot;
    logic              w_ack_last, w_dlv_last;
    logic [HND_W-1:0]  w_rd_handle;
    logic              w_rd_valid, w_nx_valid;
    srrb_pkg::t_slot_ctl w_ctl;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_load   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_op = srrb_pkg::ALU_SUB;
                w_a  = i_s_tdata[SEQ_W-1:0];
            end
            S_ACK: begin
                w_op = srrb_pkg::ALU_INC;
                w_a  = r_seq;
            end
            S_DLV: begin
                w_op = srrb_pkg::ALU_INC;
                w_a  = r_exp;
            end
            default: begin
                w_op = srrb_pkg::ALU_INC;
                w_a  = r_exp;
            end
        endcase
    end

    srrb_alu u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (r_exp),
        .o_y     (w_y),
        .o_carry (w_carry)
    );

    assign w_inside = (r_dist < SEQ_W'(WINDOW_SLOTS));
    assign w_beyond = !w_inside && !r_dist[SEQ_W-1];

    // slot of an in-window segment: expected slot plus distance, or the low sequence bits when the subtraction wrapped
    assign w_sum = {1'b0, r_exp_slot} + {1'b0, r_dist[SLOT_W-1:0]};
    always_comb begin
        if (!r_nowrap) begin
            w_wr_idx = r_seq[SLOT_W-1:0];
        end else if (w_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
            w_wr_idx = SLOT_W'(w_sum - (SLOT_W+1)'(WINDOW_SLOTS));
        end else begin
            w_wr_idx = w_sum[SLOT_W-1:0];
        end
    end

    always_comb begin
        if (r_exp == {SEQ_W{1'b1}}) begin
            w_nx_slot = '0;
        end else if (r_exp_slot == SLOT_W'(WINDOW_SLOTS - 1)) begin
            w_nx_slot = '0;
        end else begin
            w_nx_slot = r_exp_slot + SLOT_W'(1);
        end
    end

    assign w_ctl.wr  = (r_state == S_ACK) && w_load && w_inside;
    assign w_ctl.clr = (r_state == S_DLV) && w_load;

    srrb_slot_store #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SLOT_W       (SLOT_W)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_idx    (w_wr_idx),
        .i_wr_handle (r_handle),
        .i_rd_idx    (r_exp_slot),
        .i_nx_idx    (w_nx_slot),
        .o_rd_handle (w_rd_handle),
        .o_rd_valid  (w_rd_valid),
        .o_nx_valid  (w_nx_valid)
    );

    assign w_ack_last = !(w_inside && ((r_dist == '0) || w_rd_valid));
    assign w_dlv_last = !w_nx_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (w_load) begin
                    n_state = w_ack_last ? S_IDLE : S_DLV;
                end
            end
            S_DLV: begin
                if (w_load && w_dlv_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_exp      <= '0;
            r_exp_slot <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DLV) && w_load) begin
                r_exp      <= w_y;
                r_exp_slot <= w_nx_slot;
            end
            if (((r_state == S_ACK) || (r_state == S_DLV)) && w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seq    <= i_s_tdata[SEQ_W-1:0];
            r_sport  <= i_s_tdata[SEQ_W +: PORT_W];
            r_dport  <= i_s_tdata[SEQ_W+PORT_W +: PORT_W];
            r_handle <= i_s_tdata[SEQ_W+2*PORT_W +: HND_W];
            r_dist   <= w_y;
            r_nowrap <= w_carry;
        end
        if ((r_state == S_ACK) && w_load) begin
            r_kind    <= 1'b0;
            r_ack     <= w_y;
            r_rsrc    <= r_dport;
            r_rdst    <= r_sport;
            r_beyond  <= w_beyond;
            r_ohandle <= '0;
            r_oseq    <= '0;
            r_last    <= w_ack_last;
        end else if ((r_state == S_DLV) && w_load) begin
            r_kind    <= 1'b1;
            r_ack     <= '0;
            r_rsrc    <= '0;
            r_rdst    <= '0;
            r_beyond  <= 1'b0;
            r_ohandle <= w_rd_handle;
            r_oseq    <= r_exp;
            r_last    <= w_dlv_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_oseq, r_ohandle, r_beyond, r_rdst, r_rsrc, r_ack};

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench: directed segment table, then random segments against a predictor
module testbench;

    localparam int SEQ_W = srrb_pkg::SEQ_W;
    localparam int PORT_W = srrb_pkg::PORT_W;
    localparam int HANDLE_W = srrb_pkg::HANDLE_W;
    localparam int IN_DATA_W = srrb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = srrb_pkg::OUT_DATA_W;
    localparam int WINDOW = 8;
    localparam int RANDOM_ITEMS = 407;
    localparam int CALM_FROM = 350;
    localparam int DRAIN_CYCLES = 24;
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [6:0]          pad;
        logic                kind;
        logic [SEQ_W-1:0]    ack_num;
        logic [PORT_W-1:0]   reply_src;
        logic [PORT_W-1:0]   reply_dst;
        logic                beyond;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic                last;
    } t_seg_result;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [PORT_W-1:0]   src;
        logic [PORT_W-1:0]   dst;
        logic [HANDLE_W-1:0] handle;
        logic                has_ack;
        logic [SEQ_W-1:0]    ack_num;
        logic                beyond;
    } t_seg_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    t_seg_result           pending_results[$];
    logic [SEQ_W-1:0]      window_base = '0;
    logic                  slot_full[WINDOW] = '{default: 1'b0};
    logic [HANDLE_W-1:0]   slot_handle[WINDOW];

    logic                  cur_has_ack;
    logic [SEQ_W-1:0]      cur_ack_num;
    logic                  cur_beyond;
    bit                    calm;
    int                    mismatch_count = 0;
    int                    stall_left = 0;

    t_seg_row seg_table [23] = '{
        '{32'h0000_0000, 16'h0000, 16'hffff, 16'h0000, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h0000_0002, 16'hffff, 16'h0000, 16'hffff, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0003, 16'h1234, 16'h4321, 16'h1234, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0003, 16'h8000, 16'h0001, 16'habcd, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0008, 16'h0001, 16'h8000, 16'h5555, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0009, 16'h00ff, 16'hff00, 16'haaaa, 1'b1, 32'h0000_000a, 1'b1},
        '{32'h0000_0000, 16'hff00, 16'h00ff, 16'h0f0f, 1'b1, 32'h0000_0001, 1'b0},
        '{32'h0000_0001, 16'h0f0f, 16'hf0f0, 16'hf0f0, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0005, 16'h5a5a, 16'ha5a5, 16'h0005, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0006, 16'ha5a5, 16'h5a5a, 16'h0006, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0007, 16'h3333, 16'hcccc, 16'h0007, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0004, 16'hcccc, 16'h3333, 16'h0004, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000a, 16'h0010, 16'h0100, 16'h1000, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000b, 16'h0020, 16'h0200, 16'h2000, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000c, 16'h0040, 16'h0400, 16'h4000, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000d, 16'h0080, 16'h0800, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000e, 16'h7fff, 16'hfffe, 16'h7fff, 1'b0, 32'h0, 1'b0},
        '{32'h0000_000f, 16'hfffe, 16'h7fff, 16'hfffe, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0010, 16'h1111, 16'heeee, 16'h0001, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0009, 16'heeee, 16'h1111, 16'hffff, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0010, 16'h2468, 16'h8642, 16'h1357, 1'b1, 32'h8000_0011, 1'b1},
        '{32'h8000_0011, 16'h8642, 16'h2468, 16'h7531, 1'b1, 32'h8000_0012, 1'b0},
        '{32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 32'h0000_0000, 1'b0}
    };

    selective_repeat_reorder_buffer_unit #(
        .WINDOW_SLOTS(WINDOW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic string show_result(t_seg_result r);
        return $sformatf({"kind=%0d ack=%h rsrc=%h rdst=%h beyond=%0d ",
                          "handle=%h seq=%h last=%0d pad=%h"},
                         r.kind, r.ack_num, r.reply_src, r.reply_dst, r.beyond, r.handle,
                         r.seq, r.last, r.pad);
    endfunction

    // ack first, then every in-order slot released by this segment
    task automatic reorder_window_step(input logic [IN_DATA_W-1:0] d, input logic has_ack,
                                       input logic [SEQ_W-1:0] ack_num, input logic beyond);
        t_seg_result r;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] seq_gap;
        int i;
        seq = d[31:0];
        seq_gap = seq - window_base;
        r = '0;
        r.kind = KIND_ACK;
        r.ack_num = has_ack ? ack_num : seq + 32'd1;
        r.reply_src = d[63:48];
        r.reply_dst = d[47:32];
        r.beyond = has_ack ? beyond : (seq_gap >= 32'(WINDOW) && seq_gap < 32'h8000_0000);
        r.last = 1'b1;
        if (seq_gap < 32'(WINDOW)) begin
            slot_handle[seq % WINDOW] = d[79:64];
            slot_full[seq % WINDOW] = 1'b1;
            for (i = 0; i < WINDOW; i++) begin
                if (!slot_full[window_base % WINDOW]) break;
                r.last = 1'b0;
                pending_results.push_back(r);
                r = '0;
                r.kind = KIND_DELIVER;
                r.handle = slot_handle[window_base % WINDOW];
                r.seq = window_base;
                r.last = 1'b1;
                slot_full[window_base % WINDOW] = 1'b0;
                window_base = window_base + 32'd1;
            end
        end
        pending_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_seg_result got;
        t_seg_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                reorder_window_step(i_s_tdata, cur_has_ack, cur_ack_num, cur_beyond);
            if (o_m_tvalid && i_m_tready) begin
                got.pad = o_m_tdata[119:113];
                got.kind = o_m_tuser;
                got.ack_num = o_m_tdata[31:0];
                got.reply_src = o_m_tdata[47:32];
                got.reply_dst = o_m_tdata[63:48];
                got.beyond = o_m_tdata[64];
                got.handle = o_m_tdata[80:65];
                got.seq = o_m_tdata[112:81];
                got.last = o_m_tlast;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected item, expected none, actual %s",
                             $time, show_result(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: expected %s", $time, show_result(want));
                        $display("%0t: actual   %s", $time, show_result(got));
                    end
                end
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        i_m_tready <= (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [PORT_W-1:0] src,
                                input logic [PORT_W-1:0] dst, input logic [HANDLE_W-1:0] handle,
                                input logic has_ack, input logic [SEQ_W-1:0] ack_num,
                                input logic beyond);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {handle, dst, src, seq};
        cur_has_ack = has_ack;
        cur_ack_num = ack_num;
        cur_beyond = beyond;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic [SEQ_W-1:0] seq);
        send_segment(seq, 16'($urandom_range(0, 16'hffff)), 16'($urandom_range(0, 16'hffff)),
                     16'($urandom_range(0, 16'hffff)), 1'b0, '0, 1'b0);
    endtask

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int sent;
        int n;
        int k;
        int j;
        int tmp;
        int order[WINDOW];
        bit pressed;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] seq;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        cur_has_ack = 1'b0;
        cur_ack_num = '0;
        cur_beyond = 1'b0;
        calm = 1'b0;
        pressed = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (seg_table[r])
            send_segment(seg_table[r].seq, seg_table[r].src, seg_table[r].dst,
                         seg_table[r].handle, seg_table[r].has_ack, seg_table[r].ack_num,
                         seg_table[r].beyond);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= CALM_FROM)
                calm = 1'b1;
            if (!pressed && sent >= RANDOM_ITEMS / 2) begin
                // hold off until all predicted results have been received
                pressed = 1'b1;
                i_s_tvalid = 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                // shuffled segments of the current window, sometimes partial, with duplicates
                base = window_base;
                for (k = 0; k < WINDOW; k++) order[k] = k;
                for (k = WINDOW - 1; k > 0; k--) begin
                    j = $urandom_range(0, k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                n = $urandom_range(3, WINDOW);
                for (k = 0; k < n; k++) begin
                    send_random(base + order[k]);
                    sent++;
                    if ($urandom_range(0, 9) == 0) begin
                        send_random(base + order[k]);
                        sent++;
                    end
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: seq = window_base - $urandom_range(1, 16);
                    1: seq = window_base + 32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff);
                    2: seq = window_base + (($urandom_range(0, 3) == 0) ? 32'h7fff_ffff
                                                                       : $urandom_range(8, 64));
                    default: seq = $urandom();
                endcase
                send_random(seq);
                sent++;
            end
        end
        i_s_tvalid = 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/srrb_pkg.sv
hdl/srrb_alu.sv
hdl/srrb_slot_store.sv
hdl/selective_repeat_reorder_buffer_unit.sv
tb/testbench.sv
